[rtl/cdvd_pkg.sv]
// ----------------------------------------------------------------------------
// cdvd_pkg
// shared types and constants for the clause delta varint decoder
// ----------------------------------------------------------------------------
package cdvd_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned WordW    = 32;
    localparam int unsigned GroupW   = 7;
    localparam int unsigned GroupCntW = 3;

    localparam logic [GroupW-1:0]    GroupMask  = 7'h7f;
    localparam int unsigned          ContBit    = 7;
    localparam logic [GroupCntW-1:0] GroupsUsed = 3'd5;
    localparam logic [GroupCntW-1:0] GroupSat   = 3'd7;
    localparam logic [WordW-1:0]     CountSat   = 32'hffff_ffff;

    // decoder state carried from one word to the next
    typedef struct packed {
        logic                 in_header;
        logic [WordW-1:0]     varint_accum;
        logic [GroupCntW-1:0] group_index;
        logic [WordW-1:0]     clause_size;
        logic [WordW-1:0]     bytes_seen;
        logic [WordW-1:0]     last_index;
    } t_state;

    // one result item plus its valid flag
    typedef struct packed {
        logic                    valid;
        logic signed [WordW-1:0] literal;
        logic                    last_of_clause;
        logic                    empty_clause;
        logic                    order_error;
    } t_result;

endpackage

[rtl/clause_delta_varint_decoder.sv]
// ----------------------------------------------------------------------------
// clause_delta_varint_decoder
// decodes size-prefixed clauses of base-128 varint index deltas into literals
// ----------------------------------------------------------------------------
//  channel | dir | fields (lowest bit up)
//  s       | in  | tdata: byte_in[7:0]
//  m       | out | tdata: literal[31:0]; tlast: last_of_clause;
//          |     | tuser: empty_clause, order_error
//
//  one word per cycle sustained while the output is not stalled; a word is
//  decoded while it sits in the input register and its result is taken
//  into the output register as the word moves on, and offered from there
//  the decode step is one or-shift of a 7-bit group, one 32-bit add and
//  the literal mapping, between the input register and the result register
//  synchronous active-low reset returns the decoder to header parsing
//  a stalled output holds the result; the input register keeps taking words
//  as long as the word ahead can move on
module clause_delta_varint_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [cdvd_pkg::ByteW-1:0]        i_s_tdata,   // byte_in[7:0]
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic signed [cdvd_pkg::WordW-1:0] o_m_tdata,   // literal[31:0]
    output logic                              o_m_tlast,   // last_of_clause
    output logic [1:0]                        o_m_tuser    // empty_clause, order_error
);
    import cdvd_pkg::*;

    // input register
    logic              r_in_valid;
    logic [ByteW-1:0]  r_in_byte;

    // decoder state and result register
    t_state            r_state;
    t_state            n_state;
    t_result           r_out;
    t_result           n_result;

    logic              consume;

    // the held word may advance when the result slot is free or draining
    assign consume    = r_in_valid && (!r_out.valid || i_m_tready);
    assign o_s_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    cdvd_step u_step (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{in_header: 1'b1, default: '0};
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (consume) begin
            r_out <= n_result;
        end else if (i_m_tready) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_m_tvalid   = r_out.valid;
    assign o_m_tdata    = r_out.literal;
    assign o_m_tlast    = r_out.last_of_clause;
    assign o_m_tuser[0] = r_out.empty_clause;
    assign o_m_tuser[1] = r_out.order_error;

    // an empty-clause marker carries a zero literal and closes its clause
    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0 && o_m_tlast && !o_m_tuser[1]))
        else $error("empty clause marker malformed");

    // no result appears unless a held word was decoded
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && !r_out.valid) |=> !o_m_tvalid)
        else $error("result without a decoded word");

    // a clause-ending result puts the decoder back into header parsing
    a_end_to_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && n_result.valid && n_result.last_of_clause) |=> r_state.in_header)
        else $error("clause end did not return to header parsing");

endmodule

[rtl/cdvd_step.sv]
// ----------------------------------------------------------------------------
// cdvd_step
// next-state and result logic for one compressed byte
// ----------------------------------------------------------------------------
module cdvd_step (
    input  logic [cdvd_pkg::ByteW-1:0] i_byte,
    input  cdvd_pkg::t_state           i_state,
    output cdvd_pkg::t_state           o_state,
    output cdvd_pkg::t_result          o_result
);
    import cdvd_pkg::*;

    logic [WordW-1:0]       bytes_n;
    logic [WordW+GroupW-1:0] part;
    logic [WordW-1:0]       value;
    logic [WordW-1:0]       sum;
    logic [WordW-1:0]       mag;
    logic [GroupCntW+2:0]   shamt;

    always_comb begin
        bytes_n = (i_state.bytes_seen == CountSat) ? i_state.bytes_seen
                                                   : i_state.bytes_seen + 1'b1;
        // group offset is 7 * group index
        shamt = {i_state.group_index, 3'b000} - {3'b000, i_state.group_index};
        part  = {{WordW{1'b0}}, i_byte[GroupW-1:0] & GroupMask} << shamt;
        value = i_state.varint_accum;
        if (i_state.group_index < GroupsUsed) begin
            value = i_state.varint_accum | part[WordW-1:0];
        end
        sum = i_state.last_index + value;
        mag = {1'b0, sum[WordW-1:1]} + 1'b1;

        o_state            = i_state;
        o_state.bytes_seen = bytes_n;
        o_result           = '0;

        if (i_byte[ContBit]) begin
            o_state.varint_accum = value;
            if (i_state.group_index < GroupSat) begin
                o_state.group_index = i_state.group_index + 1'b1;
            end
        end else begin
            o_state.varint_accum = '0;
            o_state.group_index  = '0;
            if (i_state.in_header) begin
                o_state.clause_size = value;
                o_state.last_index  = '0;
                o_state.in_header   = 1'b0;
                if (bytes_n >= value) begin
                    // clause with no literals
                    o_result.valid          = 1'b1;
                    o_result.last_of_clause = 1'b1;
                    o_result.empty_clause   = 1'b1;
                    o_state.in_header       = 1'b1;
                    o_state.bytes_seen      = '0;
                end
            end else begin
                o_state.last_index      = sum;
                o_result.valid          = 1'b1;
                o_result.literal        = sum[0] ? mag : (~mag + 1'b1);
                o_result.order_error    = (i_state.last_index != '0) && (value == '0);
                o_result.last_of_clause = (bytes_n >= i_state.clause_size);
                if (bytes_n >= i_state.clause_size) begin
                    o_state.in_header  = 1'b1;
                    o_state.bytes_seen = '0;
                end
            end
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the clause delta varint decoder: feeds size-prefixed
// clauses of varint deltas (directed corner cases, then mostly well-formed
// random clauses with broken sizes and noise mixed in), predicts each literal
// and compares it field by field with the output stream under random stalls
// ----------------------------------------------------------------------------
module tb;

    import cdvd_pkg::*;

    typedef logic [ByteW-1:0] t_octet_q[$];

    localparam int unsigned RandomBytes  = 550;
    localparam int unsigned IdleLimit    = 2000;
    localparam int unsigned DrainCycles  = 16;

    // ------------------------------------------------------------------------
    // literal predictor and store of expected literals
    // ------------------------------------------------------------------------
    class clause_literal_board;
        logic             in_hdr;
        logic [WordW-1:0] accum;
        logic [2:0]       grp;
        logic [WordW-1:0] clause_size;
        logic [WordW-1:0] bytes_seen;
        logic [WordW-1:0] last_index;
        t_result          pending_literals[$];
        int               errors;

        function new();
            in_hdr      = 1'b1;
            accum       = '0;
            grp         = '0;
            clause_size = '0;
            bytes_seen  = '0;
            last_index  = '0;
            errors      = 0;
        endfunction

        // advance the decoder by one byte, returns 1 when a literal comes out
        function bit decode_byte(input logic [ByteW-1:0] b, output t_result r);
            logic [63:0]      part;
            logic [WordW-1:0] value;
            logic [WordW-1:0] mag;
            r = '0;
            if (bytes_seen != CountSat) bytes_seen = bytes_seen + 32'd1;
            // only the first five groups land in the 32-bit value
            if (grp < GroupsUsed) begin
                part  = 64'(b[GroupW-1:0]) << (GroupW * grp);
                accum = accum | part[WordW-1:0];
            end
            if (b[ContBit]) begin
                if (grp < GroupSat) grp = grp + 3'd1;
                return 1'b0;
            end
            value = accum;
            accum = '0;
            grp   = '0;
            if (in_hdr) begin
                clause_size = value;
                last_index  = '0;
                in_hdr      = 1'b0;
                // header alone already fills the clause
                if (bytes_seen >= clause_size) begin
                    r.valid          = 1'b1;
                    r.last_of_clause = 1'b1;
                    r.empty_clause   = 1'b1;
                    in_hdr           = 1'b1;
                    bytes_seen       = '0;
                    return 1'b1;
                end
                return 1'b0;
            end
            r.valid          = 1'b1;
            r.order_error    = (last_index != 0) && (value == 0);
            last_index       = last_index + value;
            mag              = 32'd1 + (last_index >> 1);
            r.literal        = last_index[0] ? mag : -mag;
            r.last_of_clause = (bytes_seen >= clause_size);
            if (r.last_of_clause) begin
                in_hdr     = 1'b1;
                bytes_seen = '0;
            end
            return 1'b1;
        endfunction

        function void take_byte(input logic [ByteW-1:0] b);
            t_result r;
            if (decode_byte(b, r)) pending_literals.push_back(r);
        endfunction

        function void compare_field(input string name, input longint exp_v,
                                    input longint act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name,
                         exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_literal(input logic signed [WordW-1:0] lit,
                                    input logic last, input logic [1:0] user);
            t_result e;
            if (pending_literals.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %0h", $time, lit);
                errors++;
                return;
            end
            e = pending_literals.pop_front();
            compare_field("literal", e.literal, lit);
            compare_field("last_of_clause", e.last_of_clause, last);
            compare_field("empty_clause", e.empty_clause, user[0]);
            compare_field("order_error", e.order_error, user[1]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and the block
    // ------------------------------------------------------------------------
    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [ByteW-1:0]        i_s_tdata;    // byte_in[7:0]
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic signed [WordW-1:0] o_m_tdata;    // literal[31:0]
    logic                    o_m_tlast;    // last_of_clause
    logic [1:0]              o_m_tuser;    // empty_clause, order_error

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    clause_delta_varint_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    clause_literal_board board  = new();
    // second copy of the decoder state, used only to keep the stimulus framed
    clause_literal_board framer = new();

    t_octet_q    stream;
    int unsigned idle_cycles;
    bit          send_calm;
    bit          recv_calm;

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    function automatic int varint_len(input logic [WordW-1:0] v);
        int n = 1;
        while (v >= 128) begin
            v = v >> 7;
            n++;
        end
        return n;
    endfunction

    // minimal encoding followed by pad empty groups
    function automatic void push_varint(ref t_octet_q q, input logic [WordW-1:0] v,
                                        input int pad);
        int n = varint_len(v);
        for (int k = 0; k < n + pad; k++) begin
            q.push_back({(k != n + pad - 1), v[GroupW-1:0]});
            v = v >> GroupW;
        end
    endfunction

    function automatic void put_byte(input logic [ByteW-1:0] b);
        t_result r;
        stream.push_back(b);
        void'(framer.decode_byte(b, r));
    endfunction

    function automatic void put_octets(input t_octet_q q);
        foreach (q[k]) put_byte(q[k]);
    endfunction

    // close any open varint or clause so the next byte is a fresh header
    function automatic void resync();
        int guard = 0;
        while (!(framer.in_hdr && framer.grp == 0) && guard < 200) begin
            put_byte(framer.grp != 0 ? 8'h00 : 8'h01);
            guard++;
        end
    endfunction

    function automatic logic [WordW-1:0] rand_delta(input bit first);
        int unsigned w;
        if (!first && $urandom_range(0, 19) == 0) return '0;
        w = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(0, 32);
        if (w == 0) return '0;
        return $urandom() & (32'hffff_ffff >> (32 - w));
    endfunction

    // one clause: mostly well-formed, sometimes a noisy body or a wrong size
    function automatic void put_clause();
        t_octet_q    body;
        t_octet_q    hdr;
        int unsigned kind = $urandom_range(0, 99);
        int          n_lits = $urandom_range(0, 6);
        int          pad = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 7) : 0;
        int          h = 1;
        int          size;
        if (kind < 8) begin
            // random body bytes, last one closes the varint
            repeat ($urandom_range(1, 6)) body.push_back(8'($urandom()));
            body[body.size()-1][ContBit] = 1'b0;
        end else begin
            for (int k = 0; k < n_lits; k++) push_varint(body, rand_delta(k == 0), 0);
        end
        while (varint_len(h + body.size()) + pad > h) h++;
        size = h + body.size();
        // wrong size: clause ends early or swallows the next header
        if (kind >= 8 && kind < 14) size = size + $urandom_range(1, 3);
        if (kind >= 14 && kind < 20) size = size - $urandom_range(1, 3);
        if (size < 0) size = 0;
        push_varint(hdr, size, pad);
        put_octets(hdr);
        put_octets(body);
        // stray bytes; header bytes kept small so the size stays reachable
        if ($urandom_range(0, 29) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                if (framer.in_hdr) put_byte(8'($urandom_range(0, 8'h3f)));
                else put_byte(8'($urandom()));
            end
        end
        resync();
    endfunction

    task automatic build_stream();
        int unsigned directed;
        // empty clauses: size zero and size equal to the header
        put_octets('{8'h00, 8'h01});
        // largest delta gives the most negative literal, then a zero delta
        put_octets('{8'h07, 8'hff, 8'hff, 8'hff, 8'hff, 8'h0f, 8'h00});
        // overlong varint with dropped bits, clause ending inside it
        put_octets('{8'h02, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h01});
        // zero first delta is fine, then the smallest positive literal
        put_octets('{8'h03, 8'h00, 8'h01});
        directed = stream.size();
        while (stream.size() < directed + RandomBytes) put_clause();
    endtask

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input logic [ByteW-1:0] b);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_stream();
        int unsigned gap;
        foreach (stream[k]) begin
            gap = pick_gap(send_calm);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            send_word(stream[k]);
        end
        i_s_tvalid <= 1'b0;
    endtask

    task automatic run_receiver();
        int unsigned gap;
        forever begin
            gap = pick_gap(recv_calm);
            if (gap != 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    endtask

    // stretches without idling, picked independently for each side
    initial begin
        forever begin
            repeat ($urandom_range(50, 300)) @(posedge i_clk);
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // ------------------------------------------------------------------------
    // monitor and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // note the byte first so a same-edge result could still match
            if (i_s_tvalid && o_s_tready) board.take_byte(i_s_tdata);
            if (o_m_tvalid && i_m_tready) board.check_literal(o_m_tdata, o_m_tlast, o_m_tuser);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        idle_cycles = 0;
        send_calm   = 1'b0;
        recv_calm   = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_m_tready <= 1'b0;
        build_stream();
        repeat (12) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        i_m_tready <= 1'b1;
        fork
            run_receiver();
        join_none
        send_stream();
        while (board.pending_literals.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (board.errors == 0 && board.pending_literals.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[clause_delta_varint_decoder.f]
rtl/cdvd_pkg.sv
rtl/cdvd_step.sv
rtl/clause_delta_varint_decoder.sv
test/tb.sv
